@@ hw/rtl/mma_pkg.sv @@
// Shared constants, types and state encoding for the multichannel moving average.
// Used by every file in hw/rtl; depends on nothing.
package mma_pkg;

  localparam int CHANNELS   = 4;
  localparam int WINDOW_MAX = 64;

  localparam int CH_W     = 2;                      // channel field width
  localparam int POS_W    = $clog2(WINDOW_MAX);     // ring position width
  localparam int ADDR_W   = CH_W + POS_W;           // ring memory address width
  localparam int SAMPLE_W = 32;                     // Q16.16 sample / average
  localparam int SUM_W    = 38;                     // Q22.16 running sum
  localparam int WIN_W    = 7;                      // window length register width
  localparam int RING_DEPTH = CHANNELS * WINDOW_MAX;

  // Divider retires two quotient bits per cycle (SUM_W is even).
  localparam int DIV_STEPS = SUM_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(10);
  localparam logic [WIN_W-1:0] WINDOW_LIMIT = WIN_W'(WINDOW_MAX);

  typedef enum logic [1:0] {
    ST_IDLE,   // wait for a word
    ST_RMW,    // ring data back: update ring, sum, position
    ST_DIV,    // divide the sum by the window
    ST_ZERO    // channel out of range: emit zero
  } state_t;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [SUM_W-1:0]   mag;
    logic [WIN_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hw/rtl/mma_in_if.sv @@
// Input channel: valid/ready handshake carrying one channel sample per word.
// Depends on mma_pkg.
interface mma_in_if;
  logic                                valid;
  logic                                ready;
  logic [mma_pkg::CH_W-1:0]            channel;
  logic signed [mma_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output channel, output sample_value, input ready);
  modport sink   (input valid, input channel, input sample_value, output ready);
endinterface

@@ hw/rtl/mma_out_if.sv @@
// Result channel: valid/ready handshake carrying one windowed average per word.
// Depends on mma_pkg.
interface mma_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mma_pkg::SAMPLE_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

@@ hw/rtl/multichannel_moving_average.sv @@
// Multichannel moving average, top level: running-sum windowed mean per channel.
// Depends on mma_pkg, mma_in_if, mma_out_if, mma_ring_mem and mma_div.
//
// Each input word carries one signed Q16.16 sample of one of four channels; each
// accepted word yields exactly one result word, the channel's mean over its last
// W samples (missing samples count as zero), truncated toward zero. W is the
// window length register written over cfg_wr_data, clamped to 1..64 (0 acts as 1);
// writing the register restarts every channel with an empty window. The register
// may be written only while no word is in flight. A word is accepted only once the
// previous one has passed every step: reading the leaving sample from the history
// memory, a read-modify-write of ring, sum and position, the two-bit-per-cycle
// divider and loading the output register, which waits until that register is free.
// The output register lets the next word in while an earlier result still waits
// to be taken. No clearing pass runs after reset: a per-channel fill flag makes
// ring slots that were not yet written since the last clear read as zero.
module multichannel_moving_average (
  input  logic                       clk,
  input  logic                       rst_n,
  mma_in_if.sink                     in_word,
  mma_out_if.source                  out_word,
  input  logic                       cfg_wr_en,
  input  logic [mma_pkg::WIN_W-1:0]  cfg_wr_data
);

  // Control and per-channel state.
  mma_pkg::state_t state_r, state_nxt;

  logic [mma_pkg::WIN_W-1:0]          win_size_r;
  logic [mma_pkg::WIN_W-1:0]          win_eff;
  logic signed [mma_pkg::SUM_W-1:0]   sum_r [mma_pkg::CHANNELS];
  logic [mma_pkg::POS_W-1:0]          pos_r [mma_pkg::CHANNELS];
  logic [mma_pkg::CHANNELS-1:0]       full_r;

  // Word held while it is being worked on.
  logic [mma_pkg::CH_W-1:0]           ch_r;
  logic signed [mma_pkg::SAMPLE_W-1:0] sample_r;
  logic                               ch_ok;

  // Read-modify-write datapath.
  logic                               in_acc;
  logic [mma_pkg::POS_W-1:0]          pos_cur;
  logic [mma_pkg::WIN_W-1:0]          pos_inc;
  logic                               wrap;
  logic [mma_pkg::POS_W-1:0]          pos_nxt;
  logic signed [mma_pkg::SAMPLE_W-1:0] ring_rd;
  logic signed [mma_pkg::SAMPLE_W-1:0] old_val;
  logic signed [mma_pkg::SUM_W-1:0]   sum_nxt;
  logic                               ring_wr;

  // Divider and output side.
  mma_pkg::div_req_t                  div_req;
  mma_pkg::div_rsp_t                  div_rsp;
  logic                               div_ack;
  logic                               out_free;
  logic                               out_load;
  logic signed [mma_pkg::SAMPLE_W-1:0] out_data;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [mma_pkg::SAMPLE_W-1:0] average_r;

  assign in_acc = in_word.valid && in_word.ready;

  // Clamp the requested window into 1..WINDOW_MAX.
  always_comb begin
    if (win_size_r == '0) begin
      win_eff = mma_pkg::WIN_W'(1);
    end else if (win_size_r > mma_pkg::WINDOW_LIMIT) begin
      win_eff = mma_pkg::WINDOW_LIMIT;
    end else begin
      win_eff = win_size_r;
    end
  end

  assign ch_ok = (32'(ch_r) < mma_pkg::CHANNELS);

  // Position of the slot that leaves the window; advance it modulo W.
  always_comb begin
    pos_cur = pos_r[ch_r];
    pos_inc = {1'b0, pos_cur} + 1'b1;
    wrap    = (pos_inc >= win_eff);
    pos_nxt = wrap ? '0 : pos_inc[mma_pkg::POS_W-1:0];
  end

  // Slots not yet written since the last clear count as zero.
  assign old_val = full_r[ch_r] ? ring_rd : '0;
  assign sum_nxt = sum_r[ch_r]
                 - mma_pkg::SUM_W'(old_val)
                 + mma_pkg::SUM_W'(sample_r);

  assign ring_wr = (state_r == mma_pkg::ST_RMW) && ch_ok;

  mma_ring_mem u_ring (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr ({in_word.channel, pos_r[in_word.channel]}),
    .rd_data (ring_rd),
    .wr_en   (ring_wr),
    .wr_addr ({ch_r, pos_cur}),
    .wr_data (sample_r)
  );

  // Divider request: magnitude and sign of the freshly updated sum.
  always_comb begin
    div_req.start   = ring_wr;
    div_req.neg     = sum_nxt[mma_pkg::SUM_W-1];
    div_req.mag     = sum_nxt[mma_pkg::SUM_W-1] ? (~sum_nxt + 1'b1) : sum_nxt;
    div_req.divisor = win_eff;
  end

  mma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .ack   (div_ack),
    .rsp   (div_rsp)
  );

  // Hold the word under work.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r     <= in_word.channel;
      sample_r <= in_word.sample_value;
    end
  end

  // Window register and per-channel state; a window write restarts every ring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= mma_pkg::WINDOW_RESET;
      full_r     <= '0;
      for (int i = 0; i < mma_pkg::CHANNELS; i++) begin
        sum_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      win_size_r <= cfg_wr_data;
      full_r     <= '0;
      for (int i = 0; i < mma_pkg::CHANNELS; i++) begin
        sum_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else if (ring_wr) begin
      sum_r[ch_r] <= sum_nxt;
      pos_r[ch_r] <= pos_nxt;
      if (wrap) begin
        full_r[ch_r] <= 1'b1;
      end
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mma_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = mma_pkg::ST_RMW;
        end
      end
      mma_pkg::ST_RMW: begin
        state_nxt = ch_ok ? mma_pkg::ST_DIV : mma_pkg::ST_ZERO;
      end
      mma_pkg::ST_DIV: begin
        if (div_rsp.valid && out_free) begin
          state_nxt = mma_pkg::ST_IDLE;
        end
      end
      mma_pkg::ST_ZERO: begin
        if (out_free) begin
          state_nxt = mma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mma_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_word.ready = 1'b0;
    div_ack       = 1'b0;
    out_load      = 1'b0;
    out_data      = div_rsp.quotient;
    case (state_r)
      mma_pkg::ST_IDLE: begin
        in_word.ready = 1'b1;
      end
      mma_pkg::ST_DIV: begin
        div_ack  = div_rsp.valid && out_free;
        out_load = div_rsp.valid && out_free;
      end
      mma_pkg::ST_ZERO: begin
        out_load = out_free;
        out_data = '0;
      end
      default: begin
        in_word.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register: free when empty or being drained this cycle.
  assign out_free      = !out_valid_r || out_word.ready;
  assign out_valid_nxt = out_load || (out_valid_r && !out_word.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average_r <= out_data;
    end
  end

  assign out_word.valid   = out_valid_r;
  assign out_word.average = average_r;

`ifndef NO_ASSERTIONS
  a_rmw_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mma_pkg::ST_RMW) |-> $past(in_acc))
    else $error("ring update without a freshly accepted word");

  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    ring_wr |-> ({1'b0, pos_cur} < win_eff))
    else $error("ring position outside the active window");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_word.ready))
    else $error("result loaded over one not yet taken");
`endif

endmodule

@@ hw/rtl/mma_ring_mem.sv @@
// History ring storage: one write port, one read port with registered data.
// Depends on mma_pkg.
module mma_ring_mem (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [mma_pkg::ADDR_W-1:0]          rd_addr,
  output logic signed [mma_pkg::SAMPLE_W-1:0] rd_data,
  input  logic                                wr_en,
  input  logic [mma_pkg::ADDR_W-1:0]          wr_addr,
  input  logic signed [mma_pkg::SAMPLE_W-1:0] wr_data
);

  logic signed [mma_pkg::SAMPLE_W-1:0] mem [mma_pkg::RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/mma_div.sv @@
// Sequential restoring divider: sum magnitude by window length, two bits a cycle,
// quotient sign-corrected and held until acknowledged. Depends on mma_pkg.
module mma_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mma_pkg::div_req_t req,
  input  logic              ack,
  output mma_pkg::div_rsp_t rsp
);

  logic                        busy_r;
  logic                        valid_r;
  logic [mma_pkg::CNT_W-1:0]   cnt_r;
  logic [mma_pkg::SUM_W-1:0]   num_r;
  logic [mma_pkg::SUM_W-1:0]   quo_r;
  logic [mma_pkg::WIN_W-1:0]   rem_r;
  logic [mma_pkg::WIN_W-1:0]   dvs_r;
  logic                        neg_r;

  logic [mma_pkg::WIN_W:0]     t1, t2, d1, d2;
  logic                        q1, q2;
  logic [mma_pkg::WIN_W-1:0]   r1, r2;
  logic [mma_pkg::SUM_W-1:0]   quo_sgn;

  // Two restoring steps; the remainder stays below the divisor.
  always_comb begin
    t1 = {rem_r, num_r[mma_pkg::SUM_W-1]};
    d1 = t1 - {1'b0, dvs_r};
    q1 = (t1 >= {1'b0, dvs_r});
    r1 = q1 ? d1[mma_pkg::WIN_W-1:0] : t1[mma_pkg::WIN_W-1:0];
    t2 = {r1, num_r[mma_pkg::SUM_W-2]};
    d2 = t2 - {1'b0, dvs_r};
    q2 = (t2 >= {1'b0, dvs_r});
    r2 = q2 ? d2[mma_pkg::WIN_W-1:0] : t2[mma_pkg::WIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (req.start) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
      cnt_r   <= mma_pkg::CNT_W'(mma_pkg::DIV_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r  <= 1'b0;
        valid_r <= 1'b1;
      end
    end else if (ack) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.mag;
      quo_r <= '0;
      rem_r <= '0;
      dvs_r <= req.divisor;
      neg_r <= req.neg;
    end else if (busy_r) begin
      num_r <= {num_r[mma_pkg::SUM_W-3:0], 2'b00};
      quo_r <= {quo_r[mma_pkg::SUM_W-3:0], q1, q2};
      rem_r <= r2;
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign quo_sgn      = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign rsp.valid    = valid_r;
  assign rsp.quotient = quo_sgn[mma_pkg::SAMPLE_W-1:0];

`ifndef NO_ASSERTIONS
  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> !busy_r)
    else $error("divider result flagged while still iterating");

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0 && !req.start) |=> valid_r)
    else $error("divider finished without raising its result");
`endif

endmodule

@@ tb/mma_avg_checker.sv @@
// Scoreboard for the multichannel moving average: follows the window register,
// keeps its own per-channel history and sums, and checks result words in order.
// Depends on mma_pkg.
module mma_avg_checker
  import mma_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [CH_W-1:0]            in_channel,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] out_average,
  input  logic                       cfg_wr_en,
  input  logic [WIN_W-1:0]           cfg_wr_data,
  output int                         fail_total,
  output int                         pending
);

  localparam int REPORT_LIMIT = 10;

  logic signed [SAMPLE_W-1:0] history   [CHANNELS][WINDOW_MAX];
  logic signed [SUM_W-1:0]    chan_sum  [CHANNELS];
  int unsigned                slot_next [CHANNELS];
  logic [WIN_W-1:0]           window_reg;
  logic signed [SAMPLE_W-1:0] avg_due   [$];
  int                         fail_count = 0;
  int                         due_count  = 0;

  assign fail_total = fail_count;
  assign pending    = due_count;

  function automatic void clear_history();
    for (int c = 0; c < CHANNELS; c++) begin
      chan_sum[c]  = '0;
      slot_next[c] = 0;
      for (int k = 0; k < WINDOW_MAX; k++) history[c][k] = '0;
    end
  endfunction

  // Slide one channel's window by a sample and return the mean, truncated toward zero.
  function automatic logic signed [SAMPLE_W-1:0] slide_window(
    input logic [CH_W-1:0]            ch,
    input logic signed [SAMPLE_W-1:0] smp
  );
    int unsigned span;
    int unsigned slot;
    longint      quot;
    if (window_reg == '0) span = 1;
    else if (window_reg > WINDOW_MAX) span = WINDOW_MAX;
    else span = int'(window_reg);
    slot = slot_next[ch];
    if (slot >= span) slot = 0;
    chan_sum[ch]      = chan_sum[ch] - history[ch][slot] + smp;
    history[ch][slot] = smp;
    slot_next[ch]     = (slot + 1 >= span) ? 0 : slot + 1;
    quot = longint'(chan_sum[ch]) / longint'(span);
    return SAMPLE_W'(quot);
  endfunction

  always @(posedge clk) begin : score
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      window_reg = WINDOW_RESET;
      clear_history();
      avg_due.delete();
    end else begin
      if (cfg_wr_en) begin
        window_reg = cfg_wr_data;
        clear_history();
      end
      // A result can never belong to a word accepted at this same edge.
      if (out_valid && out_ready) begin
        if (avg_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("ERROR: unexpected result word, average %0d (0x%08h)",
                     out_average, out_average);
        end else begin
          want = avg_due.pop_front();
          if (out_average !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("ERROR: average expected %0d (0x%08h), got %0d (0x%08h)",
                       want, want, out_average, out_average);
          end
        end
      end
      if (in_valid && in_ready) avg_due.push_back(slide_window(in_channel, in_sample));
    end
    due_count <= avg_due.size();
  end

endmodule

@@ tb/tb_multichannel_moving_average.sv @@
// Top of the multichannel moving average testbench: clock, reset, stimulus and verdict.
// Depends on mma_pkg, mma_in_if, mma_out_if, mma_avg_checker and the block itself.
module tb_multichannel_moving_average;
  import mma_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Give late or stray result words room to show up.
  localparam int DRAIN_CYCLES     = 30;
  localparam int CFG_SETTLE       = 2;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef enum int {RUN_MIXED, RUN_PINNED, RUN_PINNED_MAX, RUN_PINNED_MIN} run_kind_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [WIN_W-1:0] cfg_wr_data;

  int score_failures;
  int words_pending;

  // Shared with the result sink: idle odds in percent, and a request for one long hold.
  int idle_pct  = 0;
  bit long_hold = 1'b0;

  mma_in_if  in_bus ();
  mma_out_if out_bus ();

  multichannel_moving_average dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_bus),
    .out_word    (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  mma_avg_checker avg_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_bus.valid),
    .in_ready    (in_bus.ready),
    .in_channel  (in_bus.channel),
    .in_sample   (in_bus.sample_value),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_average (out_bus.average),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_total  (score_failures),
    .pending     (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: several times the slowest legal run, including the long hold.
  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result sink: drop ready in random bursts, and once hold it low for a long
  // stretch so the output register fills and the block stalls its input.
  initial begin : result_sink
    int n;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_bus.ready <= 1'b0;
        for (n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Offer one word and hold it until the block takes it. Valid stays high when
  // the next word follows right away, so it is never dropped and raised in one step.
  task automatic send_word(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] smp);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.channel      <= ch;
    in_bus.sample_value <= smp;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Write the window only once every result is back and the block sits idle.
  task automatic write_window(input logic [WIN_W-1:0] value);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One random phase: set the window, then send runs of words. Runs on a single
  // channel can be long enough to fill the ring and wrap it; pinned extreme runs
  // drive the channel sum to its limits.
  task automatic run_phase(input logic [WIN_W-1:0] value, input int items,
                           input int idle, input bit hold);
    int                         span;
    int                         sent;
    int                         run_len;
    int                         pick;
    run_kind_t                  kind;
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] smp;
    write_window(value);
    idle_pct = idle;
    if (hold) long_hold = 1'b1;
    span = (value == '0) ? 1 : (value > WINDOW_MAX) ? WINDOW_MAX : int'(value);
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 7);
      kind = (pick < 4) ? RUN_MIXED : (pick < 6) ? RUN_PINNED :
             (pick == 6) ? RUN_PINNED_MAX : RUN_PINNED_MIN;
      ch      = CH_W'($urandom_range(0, CHANNELS - 1));
      run_len = $urandom_range(1, 2 * span + 4);
      if (run_len > items - sent) run_len = items - sent;
      repeat (run_len) begin
        case ($urandom_range(0, 9))
          0:       smp = SAMPLE_MAX;
          1:       smp = SAMPLE_MIN;
          2:       smp = $signed($urandom_range(0, 2000)) - 1000;
          default: smp = $urandom();
        endcase
        case (kind)
          RUN_MIXED:      ch  = CH_W'($urandom_range(0, CHANNELS - 1));
          RUN_PINNED_MAX: smp = SAMPLE_MAX;
          RUN_PINNED_MIN: smp = SAMPLE_MIN;
          default: ;
        endcase
        send_word(ch, smp);
      end
      sent += run_len;
    end
  endtask

  initial begin : stimulus
    // Drive every input to a known value from time zero.
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.channel      <= '0;
    in_bus.sample_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window of ten: field extremes on channels 0, 1 and 3, partial windows.
    send_word(2'd0, SAMPLE_MAX);
    send_word(2'd0, SAMPLE_MAX);
    send_word(2'd0, SAMPLE_MIN);
    send_word(2'd1, SAMPLE_MIN);
    send_word(2'd1, SAMPLE_MIN);
    send_word(2'd1, -1);
    send_word(2'd2, 1);
    send_word(2'd2, -1);
    send_word(2'd2, 0);
    send_word(2'd3, SAMPLE_MAX);
    send_word(2'd3, SAMPLE_MIN);
    send_word(2'd3, -10);

    // A zero window acts as one: each average is the sample itself.
    write_window('0);
    send_word(2'd0, SAMPLE_MIN);
    send_word(2'd0, SAMPLE_MAX);
    send_word(2'd3, -7);
    send_word(2'd3, 7);

    // Windows above the maximum clamp to it; the rewrite also empties every ring.
    write_window('1);
    send_word(2'd1, SAMPLE_MIN);
    send_word(2'd1, SAMPLE_MIN);
    send_word(2'd2, -1);
    send_word(2'd2, SAMPLE_MAX);

    write_window(WIN_W'(WINDOW_MAX + 1));
    send_word(2'd0, -65);
    send_word(2'd0, SAMPLE_MAX);
    send_word(2'd3, 1);

    // Random phases over a spread of windows; the last one runs without idling.
    run_phase(WINDOW_LIMIT, 420, 25, 1'b1);
    run_phase(WIN_W'(1), 80, 40, 1'b0);
    run_phase(WIN_W'(2), 80, 10, 1'b0);
    run_phase(WIN_W'($urandom_range(3, WINDOW_MAX - 1)), 120, 25, 1'b0);
    run_phase('0, 60, 0, 1'b0);
    run_phase('1, 150, 15, 1'b0);
    run_phase(WIN_W'($urandom_range(4, WINDOW_MAX - 1)), 120, 30, 1'b0);
    run_phase(WIN_W'($urandom_range(1, WINDOW_MAX)), 200, 0, 1'b0);

    // Drain: wait for every result, then leave room for stray words.
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (score_failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
